@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Simulation gets the checks; synthesis
// sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ hw/rtl/jac_pkg.sv @@
// ----------------------------------------------------------------------------
// jac_pkg
// Shared constants, register indexes, direction codes and lane types of the
// joystick axis conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

  // Sample width default and fixed-point details of the moving average.
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int Q_BITS          = 7;
  localparam int DENOM_BIAS      = 256;

  // Register and field widths.
  localparam int DZ_W       = 10;
  localparam int HY_W       = 10;
  localparam int SHIFT_W    = 4;
  localparam int SCALE_W    = 15;
  localparam int MARGIN_W   = 11;
  localparam int DEN_W      = 12;
  localparam int NORM_W     = 16;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Register reset values.
  localparam int CENTER_RESET_VAL = 512;
  localparam int DZ_RESET_VAL     = 50;
  localparam int HY_RESET_VAL     = 10;
  localparam int SHIFT_RESET_VAL  = 3;
  localparam int SCALE_RESET_VAL  = 100;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd5;

  // Direction codes, two's complement.
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;
  localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;

  // Lane sequencer states.
  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_MUL,
    LANE_DIV_GO,
    LANE_DIV_WAIT,
    LANE_DONE
  } lane_state_t;

  // Status a lane hands to the merging stage.
  typedef struct packed {
    logic                     done;
    logic [DIR_W-1:0]         dir;
    logic signed [NORM_W-1:0] norm;
  } lane_status_t;

endpackage

@@ hw/rtl/jac_divider.sv @@
// ----------------------------------------------------------------------------
// jac_divider
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jac_divider #(
  parameter int NUM_W = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [jac_pkg::DEN_W-1:0]  den,
  output logic                       busy,
  output logic [NUM_W-1:0]           quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]          count;
  logic [jac_pkg::DEN_W-1:0] rem;
  logic [jac_pkg::DEN_W-1:0] den_hold;
  logic [jac_pkg::DEN_W:0]   rem_shift;
  logic                      fits;

  assign busy = (count != '0);

  // One trial subtraction of the shifted remainder.
  always_comb begin
    rem_shift = {rem, quot[NUM_W-1]};
    fits      = (rem_shift >= {1'b0, den_hold});
  end

  // Iteration counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quot     <= num;
      den_hold <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= jac_pkg::DEN_W'(rem_shift - {1'b0, den_hold});
      end else begin
        rem <= rem_shift[jac_pkg::DEN_W-1:0];
      end
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/jac_lane.sv @@
// ----------------------------------------------------------------------------
// jac_lane
// One axis: moving average, direction decision and normalized offset with
// its own multiplier and iterative divider.
// ----------------------------------------------------------------------------
module jac_lane #(
  parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          ack,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [SAMPLE_BITS-1:0]        center,
  input  logic                          reload,
  input  logic [SAMPLE_BITS-1:0]        reload_center,
  input  logic [jac_pkg::MARGIN_W-1:0]  margin,
  input  logic [jac_pkg::DEN_W-1:0]     denom,
  input  logic [jac_pkg::SHIFT_W-1:0]   shift,
  input  logic [jac_pkg::SCALE_W-1:0]   scale,
  output logic [SAMPLE_BITS-1:0]        smooth,
  output jac_pkg::lane_status_t         status
);

  localparam int AVG_W  = SAMPLE_BITS + jac_pkg::Q_BITS;
  localparam int NUM_W  = jac_pkg::SCALE_W + SAMPLE_BITS;
  localparam int PROD_W = jac_pkg::SCALE_W + SAMPLE_BITS + 2;
  localparam int CMP_W  = (SAMPLE_BITS > jac_pkg::MARGIN_W ? SAMPLE_BITS : jac_pkg::MARGIN_W) + 1;
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(jac_pkg::CENTER_RESET_VAL);

  jac_pkg::lane_state_t state, state_next;

  logic [AVG_W-1:0]                avg;
  logic signed [AVG_W:0]           ema_diff;
  logic signed [AVG_W:0]           ema_step;
  logic signed [AVG_W:0]           ema_sum;
  logic signed [SAMPLE_BITS:0]     offset;
  logic signed [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]               prod_mag;
  logic [CMP_W-1:0]                filt_ext;
  logic [CMP_W-1:0]                center_ext;
  logic [CMP_W-1:0]                margin_ext;
  logic [jac_pkg::DIR_W-1:0]       dir;
  logic [jac_pkg::DIR_W-1:0]       dir_calc;
  logic                            mul_load;
  logic                            div_start;
  logic                            div_busy;
  logic [NUM_W-1:0]                quot;
  logic [jac_pkg::SCALE_W-1:0]     norm_mag;

  // Moving average step: an arithmetic shift floors in both directions.
  always_comb begin
    ema_diff = $signed({1'b0, sample, {jac_pkg::Q_BITS{1'b0}}}) - $signed({1'b0, avg});
    ema_step = ema_diff >>> shift;
    ema_sum  = $signed({1'b0, avg}) + ema_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= {CENTER_RESET, {jac_pkg::Q_BITS{1'b0}}};
    end else if (reload) begin
      avg <= {reload_center, {jac_pkg::Q_BITS{1'b0}}};
    end else if (start) begin
      avg <= ema_sum[AVG_W-1:0];
    end
  end

  assign smooth = avg[AVG_W-1:jac_pkg::Q_BITS];

  // Direction against the band widened by dead zone and hysteresis.
  always_comb begin
    filt_ext   = CMP_W'(smooth);
    center_ext = CMP_W'(center);
    margin_ext = CMP_W'(margin);
    if (filt_ext + margin_ext < center_ext) begin
      dir_calc = jac_pkg::DIR_NEG;
    end else if (filt_ext > center_ext + margin_ext) begin
      dir_calc = jac_pkg::DIR_POS;
    end else begin
      dir_calc = jac_pkg::DIR_ZERO;
    end
  end

  // Signed offset times full scale, registered ahead of the divider.
  assign offset = $signed({1'b0, smooth}) - $signed({1'b0, center});

  always_ff @(posedge clk) begin
    if (mul_load) begin
      prod <= PROD_W'($signed({1'b0, scale}) * offset);
      dir  <= dir_calc;
    end
  end

  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : prod;

  jac_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_mag[NUM_W-1:0]),
    .den   (denom),
    .busy  (div_busy),
    .quot  (quot)
  );

  // Clamp the quotient magnitude and restore the sign.
  always_comb begin
    if (quot > NUM_W'(scale)) begin
      norm_mag = scale;
    end else begin
      norm_mag = quot[jac_pkg::SCALE_W-1:0];
    end
    status.done = (state == jac_pkg::LANE_DONE);
    status.dir  = dir;
    if (prod[PROD_W-1]) begin
      status.norm = -$signed({1'b0, norm_mag});
    end else begin
      status.norm = $signed({1'b0, norm_mag});
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jac_pkg::LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      jac_pkg::LANE_IDLE: begin
        if (start) state_next = jac_pkg::LANE_MUL;
      end
      jac_pkg::LANE_MUL: begin
        state_next = jac_pkg::LANE_DIV_GO;
      end
      jac_pkg::LANE_DIV_GO: begin
        state_next = jac_pkg::LANE_DIV_WAIT;
      end
      jac_pkg::LANE_DIV_WAIT: begin
        if (!div_busy) state_next = jac_pkg::LANE_DONE;
      end
      jac_pkg::LANE_DONE: begin
        if (ack) state_next = jac_pkg::LANE_IDLE;
      end
      default: begin
        state_next = jac_pkg::LANE_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    mul_load  = (state == jac_pkg::LANE_MUL);
    div_start = (state == jac_pkg::LANE_DIV_GO);
  end

endmodule

@@ hw/rtl/joystick_axis_conditioner_top.sv @@
// ----------------------------------------------------------------------------
// joystick_axis_conditioner_top
// Two-axis joystick conditioner: per-axis moving average, dead-zone direction
// and clamped normalized offset, merged with position flags and the button.
//
//   Channel  Direction  Handshake           Word contents
//   s_*      in         tvalid/tready       sample_x, sample_y, button_pressed
//   m_*      out        tvalid/tready       smoothed, direction, normalized, flags
//   cfg_*    in         cfg_we, no wait     register index and write data
//
// A new word is accepted only after the last one has left the lanes; the
// per-lane restoring divider produces one quotient bit per cycle over
// SAMPLE_BITS + 15 bits.
// The two axis lanes run side by side on the same word.
// A finished word waits in the output register while the next one is taken.
// Reset is synchronous and restores all configuration registers and both averages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module joystick_axis_conditioner_top #(
  parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Fields from bit 0: sample_x, sample_y, button_pressed.
  input  logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: smooth_x, smooth_y, direction_x, direction_y, norm_x,
  // norm_y, is_centered, is_diagonal, is_horizontal, is_vertical, button_out.
  output logic [((2*SAMPLE_BITS+41+7)/8)*8-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [jac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int OUT_W = ((2*SAMPLE_BITS+41+7)/8)*8;
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(jac_pkg::CENTER_RESET_VAL);

  // Configuration registers.
  logic [SAMPLE_BITS-1:0]           center_x;
  logic [SAMPLE_BITS-1:0]           center_y;
  logic [jac_pkg::DZ_W-1:0]         dead_zone;
  logic [jac_pkg::HY_W-1:0]         hysteresis;
  logic [jac_pkg::SHIFT_W-1:0]      smoothing_shift;
  logic [jac_pkg::SCALE_W-1:0]      full_scale;
  logic [jac_pkg::MARGIN_W-1:0]     margin;
  logic [jac_pkg::DEN_W-1:0]        denom;
  logic                             reload_x;
  logic                             reload_y;

  // Control and lane results.
  logic                             busy;
  logic                             accept;
  logic                             capture;
  logic                             button_hold;
  logic [SAMPLE_BITS-1:0]           smooth_x_lane;
  logic [SAMPLE_BITS-1:0]           smooth_y_lane;
  jac_pkg::lane_status_t            stat_x;
  jac_pkg::lane_status_t            stat_y;

  // Output word register.
  logic [SAMPLE_BITS-1:0]           out_smooth_x;
  logic [SAMPLE_BITS-1:0]           out_smooth_y;
  logic [jac_pkg::DIR_W-1:0]        out_dir_x;
  logic [jac_pkg::DIR_W-1:0]        out_dir_y;
  logic signed [jac_pkg::NORM_W-1:0] out_norm_x;
  logic signed [jac_pkg::NORM_W-1:0] out_norm_y;
  logic                             out_centered;
  logic                             out_diagonal;
  logic                             out_horizontal;
  logic                             out_vertical;
  logic                             out_button;
  logic                             nz_x;
  logic                             nz_y;

  // Configuration writes; a center write also reloads that axis average.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= CENTER_RESET;
      center_y        <= CENTER_RESET;
      dead_zone       <= jac_pkg::DZ_W'(jac_pkg::DZ_RESET_VAL);
      hysteresis      <= jac_pkg::HY_W'(jac_pkg::HY_RESET_VAL);
      smoothing_shift <= jac_pkg::SHIFT_W'(jac_pkg::SHIFT_RESET_VAL);
      full_scale      <= jac_pkg::SCALE_W'(jac_pkg::SCALE_RESET_VAL);
    end else if (cfg_we) begin
      unique case (cfg_index)
        jac_pkg::REG_CENTER_X:   center_x        <= cfg_data[SAMPLE_BITS-1:0];
        jac_pkg::REG_CENTER_Y:   center_y        <= cfg_data[SAMPLE_BITS-1:0];
        jac_pkg::REG_DEAD_ZONE:  dead_zone       <= cfg_data[jac_pkg::DZ_W-1:0];
        jac_pkg::REG_HYSTERESIS: hysteresis      <= cfg_data[jac_pkg::HY_W-1:0];
        jac_pkg::REG_SHIFT:      smoothing_shift <= cfg_data[jac_pkg::SHIFT_W-1:0];
        jac_pkg::REG_FULL_SCALE: full_scale      <= cfg_data[jac_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign reload_x = cfg_we && (cfg_index == jac_pkg::REG_CENTER_X);
  assign reload_y = cfg_we && (cfg_index == jac_pkg::REG_CENTER_Y);

  // Band half width and divisor, shared by both lanes.
  assign margin = {1'b0, dead_zone} + {1'b0, hysteresis};
  assign denom  = jac_pkg::DEN_W'(margin) + jac_pkg::DEN_W'(jac_pkg::DENOM_BIAS);

  // Word control: one word in the lanes at a time.
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign capture  = busy && stat_x.done && stat_y.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (capture) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      button_hold <= s_tdata[2*SAMPLE_BITS];
    end
  end

  // Axis lanes.
  jac_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_x (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .ack           (capture),
    .sample        (s_tdata[SAMPLE_BITS-1:0]),
    .center        (center_x),
    .reload        (reload_x),
    .reload_center (cfg_data[SAMPLE_BITS-1:0]),
    .margin        (margin),
    .denom         (denom),
    .shift         (smoothing_shift),
    .scale         (full_scale),
    .smooth        (smooth_x_lane),
    .status        (stat_x)
  );

  jac_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_y (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .ack           (capture),
    .sample        (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .center        (center_y),
    .reload        (reload_y),
    .reload_center (cfg_data[SAMPLE_BITS-1:0]),
    .margin        (margin),
    .denom         (denom),
    .shift         (smoothing_shift),
    .scale         (full_scale),
    .smooth        (smooth_y_lane),
    .status        (stat_y)
  );

  // Merge the lane directions into position flags.
  assign nz_x = (stat_x.dir != jac_pkg::DIR_ZERO);
  assign nz_y = (stat_y.dir != jac_pkg::DIR_ZERO);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_smooth_x   <= smooth_x_lane;
      out_smooth_y   <= smooth_y_lane;
      out_dir_x      <= stat_x.dir;
      out_dir_y      <= stat_y.dir;
      out_norm_x     <= stat_x.norm;
      out_norm_y     <= stat_y.norm;
      out_centered   <= !nz_x && !nz_y;
      out_diagonal   <= nz_x && nz_y;
      out_horizontal <= nz_x && !nz_y;
      out_vertical   <= !nz_x && nz_y;
      out_button     <= button_hold;
    end
  end

  assign m_tdata = OUT_W'({out_button, out_vertical, out_horizontal, out_diagonal,
                           out_centered, out_norm_y, out_norm_x, out_dir_y, out_dir_x,
                           out_smooth_y, out_smooth_x});

  // Both lanes run the same fixed sequence and must finish together.
  `ASSERT_ALWAYS(lanes_in_step, clk, rst, stat_x.done == stat_y.done, "axis lanes out of step")
  // A word leaves the lanes only while one is in flight.
  `ASSERT_IMPLY(capture_when_busy, clk, rst, capture, busy, "capture without a word in flight")
  // A high-side x direction never pairs with a negative x normalized offset.
  `ASSERT_IMPLY(pos_dir_nonneg, clk, rst, m_tvalid && (out_dir_x == jac_pkg::DIR_POS), !out_norm_x[jac_pkg::NORM_W-1], "x direction and offset sign disagree")
  // Exactly one position flag is set on every word.
  `ASSERT_IMPLY(flags_onehot, clk, rst, m_tvalid, $onehot({out_centered, out_diagonal, out_horizontal, out_vertical}), "position flags not one-hot")

endmodule

@@ test/tb_joystick_axis_conditioner_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_axis_conditioner_top
// Self-checking bench for the joystick axis conditioner. A queue of sample
// words feeds a clocked stream driver. An in-bench filter model predicts each
// conditioned word when its sample is accepted. A clocked monitor compares
// every output word with the oldest prediction, field by field. The run steps
// through several register settings and three patterns of source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
module tb_joystick_axis_conditioner_top;

  // Spare register indexes that the block must ignore.
  localparam logic [jac_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [jac_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  // One input word, packed as on s_tdata from bit 0 up.
  typedef struct packed {
    logic       btn;
    logic [9:0] sy;
    logic [9:0] sx;
  } stick_sample_t;

  // One conditioned word, packed as on m_tdata from bit 0 up.
  typedef struct packed {
    logic        button;
    logic        vertical;
    logic        horizontal;
    logic        diagonal;
    logic        centered;
    logic [15:0] norm_y;
    logic [15:0] norm_x;
    logic [1:0]  dir_y;
    logic [1:0]  dir_x;
    logic [9:0]  smooth_y;
    logic [9:0]  smooth_x;
  } joy_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  // Fields from bit 0: sample_x, sample_y, button_pressed.
  logic [23:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // Fields from bit 0: smooth_x, smooth_y, direction_x, direction_y, norm_x,
  // norm_y, is_centered, is_diagonal, is_horizontal, is_vertical, button_out.
  logic [63:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [jac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Model copy of the registers and both Q7 averages.
  logic [9:0]  ctr_x = 10'(jac_pkg::CENTER_RESET_VAL);
  logic [9:0]  ctr_y = 10'(jac_pkg::CENTER_RESET_VAL);
  logic [9:0]  dz = 10'(jac_pkg::DZ_RESET_VAL);
  logic [9:0]  hyst = 10'(jac_pkg::HY_RESET_VAL);
  logic [3:0]  shift_amt = 4'(jac_pkg::SHIFT_RESET_VAL);
  logic [14:0] fscale = 15'(jac_pkg::SCALE_RESET_VAL);
  logic [16:0] avg_x = 17'(jac_pkg::CENTER_RESET_VAL << jac_pkg::Q_BITS);
  logic [16:0] avg_y = 17'(jac_pkg::CENTER_RESET_VAL << jac_pkg::Q_BITS);

  stick_sample_t pending_samples[$];
  joy_word_t     awaited_words[$];
  stick_sample_t on_bus;
  int send_gap_pct = 16;
  int recv_stall_pct = 61;
  int mismatch_count = 0;
  int cycle_count = 0;

  joystick_axis_conditioner_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One moving-average step; the arithmetic shift floors negative steps.
  function automatic logic [16:0] ema_next(logic [16:0] avg, logic [9:0] sample);
    longint signed cur, target, diff;
    cur = longint'(avg);
    target = longint'({sample, 7'b0});
    diff = target - cur;
    return 17'(cur + (diff >>> shift_amt));
  endfunction

  // Direction against the band widened by dead zone and hysteresis.
  function automatic logic [1:0] axis_direction(int filt, int ctr);
    int margin;
    margin = int'(dz) + int'(hyst);
    if (filt < ctr - margin) return jac_pkg::DIR_NEG;
    if (filt > ctr + margin) return jac_pkg::DIR_POS;
    return jac_pkg::DIR_ZERO;
  endfunction

  // Scaled offset, truncated toward zero and clamped to the full scale.
  function automatic logic [15:0] axis_offset(int filt, int ctr);
    int lim, n;
    lim = int'(fscale);
    n = (lim * (filt - ctr)) / (int'(dz) + int'(hyst) + jac_pkg::DENOM_BIAS);
    if (n < -lim) n = -lim;
    if (n > lim) n = lim;
    return n[15:0];
  endfunction

  // Advances both filters by one sample and forms the conditioned word.
  function automatic joy_word_t filter_and_classify(stick_sample_t s);
    joy_word_t w;
    int fx, fy;
    avg_x = ema_next(avg_x, s.sx);
    avg_y = ema_next(avg_y, s.sy);
    fx = int'(avg_x[16:7]);
    fy = int'(avg_y[16:7]);
    w.smooth_x   = avg_x[16:7];
    w.smooth_y   = avg_y[16:7];
    w.dir_x      = axis_direction(fx, int'(ctr_x));
    w.dir_y      = axis_direction(fy, int'(ctr_y));
    w.norm_x     = axis_offset(fx, int'(ctr_x));
    w.norm_y     = axis_offset(fy, int'(ctr_y));
    w.centered   = (w.dir_x == jac_pkg::DIR_ZERO) && (w.dir_y == jac_pkg::DIR_ZERO);
    w.diagonal   = (w.dir_x != jac_pkg::DIR_ZERO) && (w.dir_y != jac_pkg::DIR_ZERO);
    w.horizontal = (w.dir_x != jac_pkg::DIR_ZERO) && (w.dir_y == jac_pkg::DIR_ZERO);
    w.vertical   = (w.dir_x == jac_pkg::DIR_ZERO) && (w.dir_y != jac_pkg::DIR_ZERO);
    w.button     = s.btn;
    return w;
  endfunction

  // Source side: present queued words with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_words.push_back(filter_and_classify(on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = pending_samples.pop_front();
          s_tdata <= {3'b000, on_bus};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic [15:0] want_v, logic [15:0] got_v);
    $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
    mismatch_count++;
  endtask

  // Sink side: random stalls and a field-by-field compare of each word.
  always @(posedge clk) begin
    joy_word_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got = m_tdata[60:0];
        if (awaited_words.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, got 0x%0h", $time, got);
          mismatch_count++;
        end else begin
          want = awaited_words.pop_front();
          if (got.smooth_x !== want.smooth_x)
            report_mismatch("smooth_x", 16'(want.smooth_x), 16'(got.smooth_x));
          if (got.smooth_y !== want.smooth_y)
            report_mismatch("smooth_y", 16'(want.smooth_y), 16'(got.smooth_y));
          if (got.dir_x !== want.dir_x)
            report_mismatch("direction_x", 16'(want.dir_x), 16'(got.dir_x));
          if (got.dir_y !== want.dir_y)
            report_mismatch("direction_y", 16'(want.dir_y), 16'(got.dir_y));
          if (got.norm_x !== want.norm_x) report_mismatch("norm_x", want.norm_x, got.norm_x);
          if (got.norm_y !== want.norm_y) report_mismatch("norm_y", want.norm_y, got.norm_y);
          if (got.centered !== want.centered)
            report_mismatch("is_centered", 16'(want.centered), 16'(got.centered));
          if (got.diagonal !== want.diagonal)
            report_mismatch("is_diagonal", 16'(want.diagonal), 16'(got.diagonal));
          if (got.horizontal !== want.horizontal)
            report_mismatch("is_horizontal", 16'(want.horizontal), 16'(got.horizontal));
          if (got.vertical !== want.vertical)
            report_mismatch("is_vertical", 16'(want.vertical), 16'(got.vertical));
          if (got.button !== want.button)
            report_mismatch("button_out", 16'(want.button), 16'(got.button));
        end
      end
    end
  end

  // Register write: the block samples it at the following edge.
  task automatic write_reg(logic [jac_pkg::CFG_IDX_W-1:0] idx,
                           logic [jac_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      jac_pkg::REG_CENTER_X: begin
        ctr_x = value[9:0];
        avg_x = {value[9:0], 7'b0};
      end
      jac_pkg::REG_CENTER_Y: begin
        ctr_y = value[9:0];
        avg_y = {value[9:0], 7'b0};
      end
      jac_pkg::REG_DEAD_ZONE:  dz = value[9:0];
      jac_pkg::REG_HYSTERESIS: hyst = value[9:0];
      jac_pkg::REG_SHIFT:      shift_amt = value[3:0];
      jac_pkg::REG_FULL_SCALE: fscale = value[14:0];
      default: ;
    endcase
  endtask

  task automatic end_writes;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [14:0] cx, logic [14:0] cy, logic [14:0] dzv,
                           logic [14:0] hyv, logic [14:0] shv, logic [14:0] fsv);
    write_reg(jac_pkg::REG_CENTER_X, cx);
    write_reg(jac_pkg::REG_CENTER_Y, cy);
    write_reg(jac_pkg::REG_DEAD_ZONE, dzv);
    write_reg(jac_pkg::REG_HYSTERESIS, hyv);
    write_reg(jac_pkg::REG_SHIFT, shv);
    write_reg(jac_pkg::REG_FULL_SCALE, fsv);
    end_writes();
  endtask

  task automatic queue_sample(logic [9:0] sx, logic [9:0] sy, logic btn);
    stick_sample_t s;
    s.sx = sx;
    s.sy = sy;
    s.btn = btn;
    pending_samples.push_back(s);
  endtask

  // Wait until every queued word has gone in and every result has come out.
  task automatic wait_drained;
    while (pending_samples.size() != 0 || s_tvalid || awaited_words.size() != 0)
      @(posedge clk);
  endtask

  function automatic int pick_target(int ctr);
    case ($urandom_range(3))
      0: return 0;
      1: return 1023;
      2: return ctr;
      default: return int'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [9:0] jitter(int t);
    int v;
    v = t + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // Mostly held stick positions with small jitter, so that slow filters still
  // reach the band edges; the rest is raw noise.
  task automatic queue_gestures(int count);
    int done_n, run, tx, ty, i;
    bit noisy;
    done_n = 0;
    while (done_n < count) begin
      noisy = ($urandom_range(9) < 3);
      run = int'($urandom_range(40, 1));
      tx = pick_target(int'(ctr_x));
      ty = pick_target(int'(ctr_y));
      for (i = 0; i < run && done_n < count; i++) begin
        if (noisy)
          queue_sample(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                       1'($urandom_range(1)));
        else
          queue_sample(jitter(tx), jitter(ty), 1'($urandom_range(1)));
        done_n++;
      end
    end
  endtask

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_joystick_axis_conditioner_top: errors");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: push both axes to opposite ends, then bit patterns.
    repeat (4) queue_sample(10'd1023, 10'd0, 1'b1);
    repeat (4) queue_sample(10'd0, 10'd1023, 1'b0);
    queue_sample(10'd512, 10'd512, 1'b1);
    queue_sample(10'h155, 10'h2AA, 1'b0);
    queue_sample(10'h2AA, 10'h155, 1'b1);
    wait_drained();

    // Zero shift: the filter follows each sample at once, giving all four
    // position flags in turn.
    write_reg(jac_pkg::REG_SHIFT, 15'd0);
    end_writes();
    queue_sample(10'd1023, 10'd1023, 1'b1);
    queue_sample(10'd0, 10'd0, 1'b0);
    queue_sample(10'd512, 10'd600, 1'b1);
    queue_sample(10'd700, 10'd512, 1'b0);
    queue_sample(10'd500, 10'd530, 1'b1);
    wait_drained();

    // Largest shift, with a center written with bits above its width; a
    // target below the average still pulls it down by one step.
    write_reg(jac_pkg::REG_CENTER_X, 15'h7C00 | 15'd1000);
    write_reg(jac_pkg::REG_SHIFT, 15'd15);
    end_writes();
    repeat (2) queue_sample(10'd0, 10'd0, 1'b0);
    wait_drained();

    // Band wider than the sample range, zero full scale, spare indexes.
    write_reg(jac_pkg::REG_DEAD_ZONE, 15'h7FFF);
    write_reg(jac_pkg::REG_HYSTERESIS, 15'd1023);
    write_reg(jac_pkg::REG_FULL_SCALE, 15'd0);
    write_reg(jac_pkg::REG_SHIFT, 15'd0);
    write_reg(REG_SPARE_LO, 15'h7FFF);
    write_reg(REG_SPARE_HI, 15'h1234);
    end_writes();
    queue_sample(10'd0, 10'd1023, 1'b1);
    queue_sample(10'd1023, 10'd0, 1'b0);
    wait_drained();

    // Random phases over a range of settings and three idling patterns.
    for (p = 0; p < 10; p++) begin
      if (p == 4) begin
        send_gap_pct = 61;
        recv_stall_pct = 16;
      end
      if (p == 7) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: configure(15'd0, 15'd1023, 15'd0, 15'd0, 15'd0, 15'd32767);
        1: configure(15'd1023, 15'd0, 15'd1023, 15'd1023, 15'd15, 15'd0);
        2: configure(15'd512, 15'd512, 15'd50, 15'd10, 15'd3, 15'd100);
        default: configure(15'($urandom_range(1023)), 15'($urandom_range(1023)),
                           15'($urandom_range(200)), 15'($urandom_range(60)),
                           15'($urandom_range(7)), 15'($urandom_range(32767)));
      endcase
      queue_gestures(195);
      wait_drained();
    end

    // Watch for stray words before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_joystick_axis_conditioner_top: clean");
    else
      $display("tb_joystick_axis_conditioner_top: errors");
    $finish;
  end

endmodule

@@ joystick_axis_conditioner_top.f @@
+incdir+hw/rtl
hw/rtl/jac_pkg.sv
hw/rtl/jac_divider.sv
hw/rtl/jac_lane.sv
hw/rtl/joystick_axis_conditioner_top.sv
test/tb_joystick_axis_conditioner_top.sv
